FILE: sv/fmcl_pkg.sv
package fmcl_pkg;

    localparam int WINDOW_SIZE_DEFAULT = 16;
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int COUNT_BITS_DEFAULT  = 20;

    localparam int THRESHOLD_BITS = 12;
    localparam int AVERAGE_BITS   = 12;
    localparam int PHASE_BITS     = 2;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd120;

    localparam logic [PHASE_BITS-1:0] PHASE_WAIT_CLOSE = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_CLOSING    = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_HOLDING    = 2'd2;
    localparam logic [PHASE_BITS-1:0] PHASE_OPENING    = 2'd3;

    typedef struct packed {
        logic                  drive_close;
        logic                  drive_open;
        logic [PHASE_BITS-1:0] motion_phase;
    } phase_out_t;

endpackage

FILE: sv/finger_motor_current_limit_fsm.sv
// An input goes to the stage register and its result to the output register; stalls delay it.
// Throughput: one item per cycle unless the output stalls, set by the single compute
// stage between input and output registers; the ring is one read-first RAM access per item.
// Reset clears the phase machine, count, running sum and threshold (to 120) at once;
// ring entries read as zero until the ring has wrapped, so there is no clearing pass.
module finger_motor_current_limit_fsm #(
    parameter int WINDOW_SIZE = fmcl_pkg::WINDOW_SIZE_DEFAULT,
    parameter int SAMPLE_BITS = fmcl_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = fmcl_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 current_threshold_we,
    input  logic [fmcl_pkg::THRESHOLD_BITS-1:0]  current_threshold,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SAMPLE_BITS-1:0]               current_sample,
    input  logic                                 close_request,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 drive_close,
    output logic                                 drive_open,
    output logic [fmcl_pkg::PHASE_BITS-1:0]      motion_phase,
    output logic [COUNT_BITS-1:0]                close_duration,
    output logic [fmcl_pkg::AVERAGE_BITS-1:0]    average_level
);

    import fmcl_pkg::*;

    localparam int WIDE_BITS = (SAMPLE_BITS > AVERAGE_BITS) ? SAMPLE_BITS : AVERAGE_BITS;

    logic [THRESHOLD_BITS-1:0] threshold_reg;
    logic                      stage_valid_reg;
    logic [SAMPLE_BITS-1:0]    stage_sample_reg;
    logic                      stage_close_reg;
    logic                      out_valid_reg;
    logic                      drive_close_reg;
    logic                      drive_open_reg;
    logic [PHASE_BITS-1:0]     motion_phase_reg;
    logic [COUNT_BITS-1:0]     close_duration_reg;
    logic [AVERAGE_BITS-1:0]   average_level_reg;

    logic                      in_xfer;
    logic                      commit;
    logic [SAMPLE_BITS-1:0]    mean;
    logic [WIDE_BITS-1:0]      mean_wide;
    phase_out_t                phase_result;
    logic [COUNT_BITS-1:0]     count_next;

    assign commit    = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || commit;
    assign in_xfer   = in_valid && in_ready;
    assign mean_wide = WIDE_BITS'(mean);

    fmcl_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_xfer      (in_xfer),
        .in_sample    (current_sample),
        .commit       (commit),
        .stage_sample (stage_sample_reg),
        .mean         (mean)
    );

    fmcl_phase #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .close_req  (stage_close_reg),
        .mean       (mean),
        .threshold  (threshold_reg),
        .result     (phase_result),
        .count_next (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (current_threshold_we)
            begin
                threshold_reg <= current_threshold;
            end
            if (in_xfer)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_sample_reg <= current_sample;
            stage_close_reg  <= close_request;
        end
        if (commit)
        begin
            drive_close_reg    <= phase_result.drive_close;
            drive_open_reg     <= phase_result.drive_open;
            motion_phase_reg   <= phase_result.motion_phase;
            close_duration_reg <= count_next;
            average_level_reg  <= mean_wide[AVERAGE_BITS-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_close    = drive_close_reg;
    assign drive_open     = drive_open_reg;
    assign motion_phase   = motion_phase_reg;
    assign close_duration = close_duration_reg;
    assign average_level  = average_level_reg;

`ifndef ASSERT_OFF
    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_close && drive_open))
        else $error("Close and open drive are both active.");

    a_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_close) |-> (motion_phase == PHASE_CLOSING))
        else $error("Close drive outside the closing phase.");

    a_open_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_open) |-> (motion_phase == PHASE_OPENING))
        else $error("Open drive outside the opening phase.");

    a_wait_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motion_phase == PHASE_WAIT_CLOSE) |-> (close_duration == '0))
        else $error("Count not cleared while waiting to close.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && out_valid && !out_ready))
        else $error("Input stalled without a full pipeline.");
`endif

endmodule

FILE: sv/fmcl_ram.sv
module fmcl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a write returns the old contents of the same entry.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem_reg[addr];
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fmcl_window.sv
module fmcl_window #(
    parameter int WINDOW_SIZE = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_xfer,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   commit,
    input  logic [SAMPLE_BITS-1:0] stage_sample,
    output logic [SAMPLE_BITS-1:0] mean
);

    localparam int POS_BITS = $clog2(WINDOW_SIZE);
    localparam int SUM_BITS = SAMPLE_BITS + POS_BITS;
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(WINDOW_SIZE - 1);

    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    pos_next;
    logic                   filled_reg;
    logic                   old_valid_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SAMPLE_BITS-1:0] old_term;

    // Entries read as zero until the ring has wrapped once after reset.
    fmcl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .clk   (clk),
        .en    (in_xfer),
        .we    (in_xfer),
        .addr  (pos_reg),
        .wdata (in_sample),
        .rdata (old_sample)
    );

    assign pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_BITS'(1);
    assign old_term = old_valid_reg ? old_sample : '0;
    assign sum_next = sum_reg - SUM_BITS'(old_term) + SUM_BITS'(stage_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            old_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                pos_reg       <= pos_next;
                old_valid_reg <= filled_reg;
                if (pos_reg == POS_LAST)
                begin
                    filled_reg <= 1'b1;
                end
            end
            if (commit)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    generate
        if ((1 << POS_BITS) == WINDOW_SIZE)
        begin : g_shift
            assign mean = sum_next[POS_BITS +: SAMPLE_BITS];
        end
        else
        begin : g_recip
            // Exact truncated quotient by a rounded-up reciprocal.
            localparam int RECIP_BITS = SUM_BITS + 1;
            localparam int SHIFT      = SUM_BITS + POS_BITS;
            localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
            localparam longint unsigned RECIP_FULL =
                ((64'd1 << SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
            localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

            logic [PROD_BITS-1:0] product;

            assign product = PROD_BITS'(sum_next) * PROD_BITS'(RECIP);
            assign mean    = product[SHIFT +: SAMPLE_BITS];
        end
    endgenerate

endmodule

FILE: sv/fmcl_phase.sv
module fmcl_phase #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  commit,
    input  logic                                  close_req,
    input  logic [SAMPLE_BITS-1:0]                mean,
    input  logic [fmcl_pkg::THRESHOLD_BITS-1:0]   threshold,
    output fmcl_pkg::phase_out_t                  result,
    output logic [COUNT_BITS-1:0]                 count_next
);

    import fmcl_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [PHASE_BITS-1:0] {
        ST_WAIT_CLOSE = PHASE_WAIT_CLOSE,
        ST_CLOSING    = PHASE_CLOSING,
        ST_HOLDING    = PHASE_HOLDING,
        ST_OPENING    = PHASE_OPENING
    } phase_state_t;

    phase_state_t            phase_reg;
    phase_state_t            phase_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic                    dc;
    logic                    dopen;
    logic [CMP_BITS-1:0]     mean_wide;
    logic [CMP_BITS-1:0]     thr_wide;

    assign mean_wide = CMP_BITS'(mean);
    assign thr_wide  = CMP_BITS'(threshold);

    always_comb
    begin
        phase_next = phase_reg;
        dc         = 1'b0;
        dopen      = 1'b0;
        if (close_req)
        begin
            unique case (phase_reg) inside
                ST_WAIT_CLOSE, ST_OPENING:
                begin
                    phase_next = ST_CLOSING;
                end
                ST_CLOSING:
                begin
                    if (mean_wide < thr_wide)
                    begin
                        dc = 1'b1;
                    end
                    else
                    begin
                        phase_next = ST_HOLDING;
                    end
                end
                default:
                begin
                    phase_next = ST_HOLDING;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg) inside
                ST_OPENING:
                begin
                    if (count_reg != '0)
                    begin
                        dopen = 1'b1;
                    end
                    else
                    begin
                        phase_next = ST_WAIT_CLOSE;
                    end
                end
                ST_WAIT_CLOSE:
                begin
                    phase_next = ST_WAIT_CLOSE;
                end
                default:
                begin
                    phase_next = ST_OPENING;
                end
            endcase
        end
    end

    // The opening-time count follows the phase just entered.
    always_comb
    begin
        count_next = count_reg;
        unique case (phase_next)
            ST_OPENING:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_ONE;
                end
            end
            ST_WAIT_CLOSE:
            begin
                count_next = '0;
            end
            ST_CLOSING:
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + COUNT_ONE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign result.drive_close  = dc;
    assign result.drive_open   = dopen;
    assign result.motion_phase = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ST_WAIT_CLOSE;
            count_reg <= '0;
        end
        else if (commit)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fmcl_pkg::*;

    localparam int WINDOW      = WINDOW_SIZE_DEFAULT;
    localparam int SBITS       = SAMPLE_BITS_DEFAULT;
    localparam int CBITS       = COUNT_BITS_DEFAULT;
    localparam int SLOT_BITS   = $clog2(WINDOW);
    localparam int SUM_BITS    = SBITS + SLOT_BITS;
    localparam int STALL_TICKS = 200;
    localparam int DRAIN_TICKS = 10;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic                      drive_close;
        logic                      drive_open;
        logic [PHASE_BITS-1:0]     motion_phase;
        logic [CBITS-1:0]          close_duration;
        logic [AVERAGE_BITS-1:0]   average_level;
    } finger_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      current_threshold_we;
    logic [THRESHOLD_BITS-1:0] current_threshold;
    logic                      in_valid;
    logic                      in_ready;
    logic [SBITS-1:0]          current_sample;
    logic                      close_request;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      drive_close;
    logic                      drive_open;
    logic [PHASE_BITS-1:0]     motion_phase;
    logic [CBITS-1:0]          close_duration;
    logic [AVERAGE_BITS-1:0]   average_level;

    logic [SBITS-1:0]          exp_ring [WINDOW];
    logic [SLOT_BITS-1:0]      exp_slot;
    logic [SUM_BITS-1:0]       exp_sum;
    logic [PHASE_BITS-1:0]     exp_phase;
    logic [CBITS-1:0]          exp_ticks;
    logic [THRESHOLD_BITS-1:0] exp_limit;

    finger_result_t pending_results[$];
    int             mismatch_count = 0;
    bit             source_idle_on = 1'b1;
    logic           sink_idle_on = 1'b1;
    logic           sink_hold = 1'b0;
    int             sink_gap = 0;
    event           stall_start;

    finger_motor_current_limit_fsm dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .current_threshold_we (current_threshold_we),
        .current_threshold    (current_threshold),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .current_sample       (current_sample),
        .close_request        (close_request),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .drive_close          (drive_close),
        .drive_open           (drive_open),
        .motion_phase         (motion_phase),
        .close_duration       (close_duration),
        .average_level        (average_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic finger_result_t step_finger(input logic [SBITS-1:0] sample,
                                                   input logic close_req);
        finger_result_t          r;
        logic [AVERAGE_BITS-1:0] mean;
        r = '0;
        exp_sum = exp_sum - exp_ring[exp_slot] + sample;
        exp_ring[exp_slot] = sample;
        exp_slot = (exp_slot == SLOT_BITS'(WINDOW - 1)) ? '0 : exp_slot + 1'b1;
        mean = AVERAGE_BITS'(exp_sum / WINDOW);
        if (close_req)
        begin
            case (exp_phase)
                PHASE_WAIT_CLOSE, PHASE_OPENING: exp_phase = PHASE_CLOSING;
                PHASE_CLOSING:
                begin
                    if (mean < exp_limit)
                        r.drive_close = 1'b1;
                    else
                        exp_phase = PHASE_HOLDING;
                end
                default: exp_phase = PHASE_HOLDING;
            endcase
        end
        else
        begin
            case (exp_phase)
                PHASE_OPENING:
                begin
                    if (exp_ticks != '0)
                        r.drive_open = 1'b1;
                    else
                        exp_phase = PHASE_WAIT_CLOSE;
                end
                PHASE_WAIT_CLOSE: ;
                default: exp_phase = PHASE_OPENING;
            endcase
        end
        case (exp_phase)
            PHASE_OPENING:
            begin
                if (exp_ticks != '0)
                    exp_ticks = exp_ticks - 1'b1;
            end
            PHASE_WAIT_CLOSE: exp_ticks = '0;
            PHASE_CLOSING:
            begin
                if (exp_ticks != '1)
                    exp_ticks = exp_ticks + 1'b1;
            end
            default: ;
        endcase
        r.motion_phase   = exp_phase;
        r.close_duration = exp_ticks;
        r.average_level  = mean;
        return r;
    endfunction

    task automatic send_item(input logic [SBITS-1:0] sample, input logic close_req);
        int gap;
        gap = source_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        current_sample <= sample;
        close_request  <= close_req;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(step_finger(sample, close_req));
    endtask

    task automatic set_threshold(input logic [THRESHOLD_BITS-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        current_threshold_we <= 1'b1;
        current_threshold    <= value;
        @(posedge clk);
        current_threshold_we <= 1'b0;
        exp_limit = value;
    endtask

    task automatic test_phase_walk();
        int k;
        send_item(12'd0, 1'b0);
        send_item(12'd0, 1'b1);
        for (k = 0; k < 2; k++)
            send_item(12'd1, 1'b1);
        send_item(12'hFFF, 1'b1);
        send_item(12'h800, 1'b1);
        for (k = 0; k < 4; k++)
            send_item(12'd0, 1'b0);
    endtask

    task automatic test_reclose_keeps_count();
        int k;
        set_threshold(12'hFFF);
        for (k = 0; k < 3; k++)
            send_item(SBITS'($urandom_range(0, 4094)), 1'b1);
        for (k = 0; k < 2; k++)
            send_item(SBITS'($urandom_range(0, 4095)), 1'b0);
        for (k = 0; k < 2; k++)
            send_item(SBITS'($urandom_range(0, 4094)), 1'b1);
        for (k = 0; k < 4; k++)
            send_item(SBITS'($urandom_range(0, 4095)), 1'b0);
    endtask

    task automatic test_threshold_floor();
        set_threshold(12'd0);
        send_item(12'd0, 1'b1);
        send_item(12'd0, 1'b1);
        send_item(12'hFFF, 1'b0);
        send_item(12'd0, 1'b0);
    endtask

    task automatic test_random_motion(input int item_budget);
        int sent;
        int close_len;
        int open_len;
        int shift;
        int k;
        sent = 0;
        while (sent < item_budget)
        begin
            source_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on  <= ($urandom_range(0, 3) != 0);
            shift = $urandom_range(0, 8);
            if ($urandom_range(0, 4) == 0)
            begin
                for (k = 0; k < 10; k++)
                    send_item(SBITS'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                sent += 10;
            end
            else
            begin
                close_len = $urandom_range(1, 30);
                open_len  = $urandom_range(1, 40);
                for (k = 0; k < close_len; k++)
                    send_item(SBITS'($urandom_range(0, 4095) >> shift), 1'b1);
                for (k = 0; k < open_len; k++)
                    send_item(SBITS'($urandom_range(0, 4095) >> shift), 1'b0);
                sent += close_len + open_len;
            end
        end
        source_idle_on = 1'b1;
        sink_idle_on  <= 1'b1;
    endtask

    task automatic test_pressure_stall();
        int k;
        source_idle_on = 1'b0;
        -> stall_start;
        for (k = 0; k < 40; k++)
            send_item(SBITS'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
        source_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        finger_result_t got;
        finger_result_t want;
        if (out_valid && out_ready)
        begin
            got = {drive_close, drive_open, motion_phase, close_duration, average_level};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: close=%0d open=%0d phase=%0d dur=%0d avg=%0d",
                             got.drive_close, got.drive_open, got.motion_phase,
                             got.close_duration, got.average_level);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch: expected close=%0d open=%0d phase=%0d dur=%0d avg=%0d",
                                 want.drive_close, want.drive_open, want.motion_phase,
                                 want.close_duration, want.average_level);
                        $display("          got      close=%0d open=%0d phase=%0d dur=%0d avg=%0d",
                                 got.drive_close, got.drive_open, got.motion_phase,
                                 got.close_duration, got.average_level);
                    end
                end
            end
            sink_gap = sink_idle_on ? $urandom_range(0, 9) : 0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
        end
        out_ready <= (sink_gap == 0) && !sink_hold;
    end

    initial
    begin
        forever
        begin
            @(stall_start);
            sink_hold <= 1'b1;
            repeat (STALL_TICKS) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    initial
    begin
        #(50_000_000);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        in_valid             = 1'b0;
        current_sample       = '0;
        close_request        = 1'b0;
        current_threshold_we = 1'b0;
        current_threshold    = THRESHOLD_RESET;
        for (int k = 0; k < WINDOW; k++)
            exp_ring[k] = '0;
        exp_slot  = '0;
        exp_sum   = '0;
        exp_phase = PHASE_WAIT_CLOSE;
        exp_ticks = '0;
        exp_limit = THRESHOLD_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_phase_walk();
        test_reclose_keeps_count();
        test_threshold_floor();
        set_threshold(THRESHOLD_BITS'($urandom_range(0, 4095)));
        test_random_motion(260);
        set_threshold(THRESHOLD_BITS'($urandom_range(1, 200)));
        test_random_motion(260);
        set_threshold(12'hFFF);
        test_random_motion(260);
        set_threshold(THRESHOLD_RESET);
        test_random_motion(260);
        test_pressure_stall();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
